[hw/rtl/lsf_pkg.sv]
// Shared types and constants for the line substring filter.
// No dependencies; every other file of the block imports this package.
package lsf_pkg;

   localparam int BYTE_W              = 8;
   localparam int PAT_REGS            = 4;
   localparam int PAT_BYTES           = PAT_REGS * 8;
   localparam int CSR_DATA_W          = 64;
   localparam int CSR_INDEX_W         = 3;
   localparam int LEN_REG_W           = 6;
   localparam int LINE_NUM_W          = 24;
   localparam int MAX_PATTERN_DEFAULT = 32;

   localparam logic [BYTE_W-1:0]     NEWLINE  = 8'd10;
   localparam logic [LINE_NUM_W-1:0] LINE_MAX = '1;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_PAT_0_7   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAT_8_15  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAT_16_23 = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAT_24_31 = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAT_LEN   = 3'd4;

   // Pattern as held by the register file: byte k sits in bits 8k+7..8k.
   typedef struct packed {
      logic [PAT_BYTES*BYTE_W-1:0] bytes;
      logic [LEN_REG_W-1:0]        length;
   } lsf_pattern_type;

endpackage

[hw/rtl/line_substring_filter.sv]
// Top level of the line substring filter: input register, line state, result register.
// Depends on lsf_pkg, lsf_csr and lsf_window.
//
// Usage: text arrives on the req_ channel one word per cycle, each word either a
// byte of text or an end-of-text marker. A newline byte ends a line; an
// end-of-text marker ends a line only if the line holds at least one byte.
// For every line that ends, one word leaves on the rsp_ channel carrying the
// line's 1-based number (saturating), whether the configured pattern occurred
// in that line, and whether any line so far has matched.
// The pattern is loaded through the csr_ port (four 64-bit byte registers and
// a length register) while no text is in flight; csr_ready is always high.
// Each word is evaluated from the input register; the result of a word that
// ends a line is then held in the result register, which drives rsp_. Throughput
// is one word per cycle while req_ready stays high, set by the combinational window
// compare, which checks all pattern positions against the window in parallel.
// When the receiver stalls, the result register holds its word; words that end
// no line keep flowing, and a word that ends a line waits in the input register,
// holding req_ready low, until the result register frees.
// Reset clears the pattern, the line count, the match flags and both valid bits.
module line_substring_filter #(
   parameter int MAX_PATTERN = lsf_pkg::MAX_PATTERN_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [lsf_pkg::BYTE_W-1:0]          req_text_byte,
   input  logic                                req_end_of_text,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [lsf_pkg::LINE_NUM_W-1:0]      rsp_line_number,
   output logic                                rsp_line_matched,
   output logic                                rsp_any_matched,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lsf_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [lsf_pkg::CSR_DATA_W-1:0]      csr_data
);
   import lsf_pkg::*;

   localparam int LEN_W = $clog2(MAX_PATTERN + 1);

   lsf_pattern_type pattern;

   // Input register.
   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff,  in_byte_in;
   logic              in_eot_ff,   in_eot_in;

   // Line state.
   logic [LEN_W-1:0]      bytes_in_line_ff, bytes_in_line_in;
   logic                  line_hit_ff,      line_hit_in;
   logic                  line_open_ff,     line_open_in;
   logic [LINE_NUM_W-1:0] lines_done_ff,    lines_done_in;
   logic                  any_hit_ff,       any_hit_in;

   // Result register.
   logic                  out_valid_ff,   out_valid_in;
   logic [LINE_NUM_W-1:0] out_number_ff,  out_number_in;
   logic                  out_matched_ff, out_matched_in;
   logic                  out_any_ff,     out_any_in;

   logic             is_text;
   logic             ends_line;
   logic             advance;
   logic [LEN_W-1:0] count_next;
   logic             window_hit;
   logic             hit_final;
   logic             pat_empty;

   lsf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .pattern   (pattern)
   );

   // A word in the input register either carries a text byte into the window
   // or closes the open line; an end-of-text marker with no open line does neither.
   assign is_text   = !in_eot_ff && (in_byte_ff != NEWLINE);
   assign ends_line = in_eot_ff ? line_open_ff : (in_byte_ff == NEWLINE);

   // A word that produces a result moves only when the result register can take it.
   assign advance   = in_valid_ff && (!ends_line || !out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   assign count_next = (bytes_in_line_ff == LEN_W'(MAX_PATTERN)) ? bytes_in_line_ff
                                                                  : bytes_in_line_ff + 1'b1;

   lsf_window #(
      .MAX_PATTERN (MAX_PATTERN),
      .LEN_W       (LEN_W)
   ) u_window (
      .clock      (clock),
      .shift_en   (advance && is_text),
      .text_byte  (in_byte_ff),
      .count_next (count_next),
      .pattern    (pattern),
      .window_hit (window_hit)
   );

   assign pat_empty = (pattern.length == '0);
   assign hit_final = line_hit_ff || pat_empty;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_eot_in   = in_eot_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_text_byte;
         in_eot_in   = req_end_of_text;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      bytes_in_line_in = bytes_in_line_ff;
      line_hit_in      = line_hit_ff;
      line_open_in     = line_open_ff;
      lines_done_in    = lines_done_ff;
      any_hit_in       = any_hit_ff;
      out_valid_in     = out_valid_ff && !rsp_ready;
      out_number_in    = out_number_ff;
      out_matched_in   = out_matched_ff;
      out_any_in       = out_any_ff;
      if (advance) begin
         if (is_text) begin
            bytes_in_line_in = count_next;
            line_open_in     = 1'b1;
            line_hit_in      = line_hit_ff || window_hit;
         end else if (ends_line) begin
            // The line closes: count it, fold its hit into the running flag.
            if (lines_done_ff != LINE_MAX) begin
               lines_done_in = lines_done_ff + 1'b1;
            end
            any_hit_in       = any_hit_ff || hit_final;
            out_valid_in     = 1'b1;
            out_number_in    = lines_done_in;
            out_matched_in   = hit_final;
            out_any_in       = any_hit_in;
            bytes_in_line_in = '0;
            line_hit_in      = 1'b0;
            line_open_in     = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
         bytes_in_line_ff <= '0;
         line_hit_ff      <= 1'b0;
         line_open_ff     <= 1'b0;
         lines_done_ff    <= '0;
         any_hit_ff       <= 1'b0;
      end else begin
         in_valid_ff      <= in_valid_in;
         out_valid_ff     <= out_valid_in;
         bytes_in_line_ff <= bytes_in_line_in;
         line_hit_ff      <= line_hit_in;
         line_open_ff     <= line_open_in;
         lines_done_ff    <= lines_done_in;
         any_hit_ff       <= any_hit_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff     <= in_byte_in;
      in_eot_ff      <= in_eot_in;
      out_number_ff  <= out_number_in;
      out_matched_ff <= out_matched_in;
      out_any_ff     <= out_any_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_line_number  = out_number_ff;
   assign rsp_line_matched = out_matched_ff;
   assign rsp_any_matched  = out_any_ff;

endmodule

[hw/rtl/lsf_csr.sv]
// Configuration registers of the line substring filter: pattern bytes and length.
// Depends on lsf_pkg.
module lsf_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lsf_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [lsf_pkg::CSR_DATA_W-1:0]      csr_data,
   output lsf_pkg::lsf_pattern_type            pattern
);
   import lsf_pkg::*;

   logic [CSR_DATA_W-1:0] pat_ff [PAT_REGS];
   logic [CSR_DATA_W-1:0] pat_in [PAT_REGS];
   logic [LEN_REG_W-1:0]  len_ff;
   logic [LEN_REG_W-1:0]  len_in;

   assign csr_ready = 1'b1;

   always_comb begin
      for (int r = 0; r < PAT_REGS; r++) begin
         pat_in[r] = pat_ff[r];
      end
      len_in = len_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_PAT_0_7:   pat_in[0] = csr_data;
            CSR_PAT_8_15:  pat_in[1] = csr_data;
            CSR_PAT_16_23: pat_in[2] = csr_data;
            CSR_PAT_24_31: pat_in[3] = csr_data;
            CSR_PAT_LEN:   len_in    = csr_data[LEN_REG_W-1:0];
            default:       len_in    = len_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < PAT_REGS; r++) begin
            pat_ff[r] <= '0;
         end
         len_ff <= '0;
      end else begin
         for (int r = 0; r < PAT_REGS; r++) begin
            pat_ff[r] <= pat_in[r];
         end
         len_ff <= len_in;
      end
   end

   always_comb begin
      for (int r = 0; r < PAT_REGS; r++) begin
         pattern.bytes[r*CSR_DATA_W +: CSR_DATA_W] = pat_ff[r];
      end
      pattern.length = len_ff;
   end

endmodule

[hw/rtl/lsf_window.sv]
// Window of recent line bytes and the parallel compare against the pattern.
// Depends on lsf_pkg.
module lsf_window #(
   parameter int MAX_PATTERN = lsf_pkg::MAX_PATTERN_DEFAULT,
   parameter int LEN_W       = $clog2(MAX_PATTERN + 1)
) (
   input  logic                             clock,
   input  logic                             shift_en,
   input  logic [lsf_pkg::BYTE_W-1:0]       text_byte,
   input  logic [LEN_W-1:0]                 count_next,
   input  lsf_pkg::lsf_pattern_type         pattern,
   output logic                             window_hit
);
   import lsf_pkg::*;

   logic [BYTE_W-1:0]             window_ff [MAX_PATTERN];
   logic [BYTE_W-1:0]             window_in [MAX_PATTERN];
   logic [BYTE_W-1:0]             pat_arr   [MAX_PATTERN];
   logic [MAX_PATTERN*BYTE_W-1:0] rev_flat;
   logic [MAX_PATTERN*BYTE_W-1:0] aligned_flat;
   logic [LEN_W-1:0]              use_len;
   logic [LEN_W-1:0]              shift_amt;
   logic [MAX_PATTERN-1:0]        pos_ok;

   // Lengths beyond the window are clamped to the window size.
   always_comb begin
      if ({1'b0, pattern.length} > (LEN_REG_W + 1)'(MAX_PATTERN)) begin
         use_len = LEN_W'(MAX_PATTERN);
      end else begin
         use_len = LEN_W'(pattern.length);
      end
   end

   // Slot 0 is the newest byte, so pattern byte len-1-j lines up with slot j.
   // Reversing the pattern and shifting it down by MAX_PATTERN-len gives that order.
   for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_pat
      if (k < PAT_BYTES) begin : g_real
         assign pat_arr[k] = pattern.bytes[k*BYTE_W +: BYTE_W];
      end else begin : g_zero
         assign pat_arr[k] = '0;
      end
      assign rev_flat[k*BYTE_W +: BYTE_W] = pat_arr[MAX_PATTERN-1-k];
   end

   assign shift_amt    = LEN_W'(MAX_PATTERN) - use_len;
   assign aligned_flat = rev_flat >> {shift_amt, 3'b000};

   assign window_in[0] = text_byte;
   for (genvar j = 1; j < MAX_PATTERN; j++) begin : g_shift
      assign window_in[j] = window_ff[j-1];
   end

   for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cmp
      assign pos_ok[j] = (window_in[j] == aligned_flat[j*BYTE_W +: BYTE_W]) ||
                         (LEN_W'(j) >= use_len);
   end

   assign window_hit = (use_len == '0) || ((count_next >= use_len) && (&pos_ok));

   always_ff @(posedge clock) begin
      if (shift_en) begin
         for (int j = 0; j < MAX_PATTERN; j++) begin
            window_ff[j] <= window_in[j];
         end
      end
   end

endmodule
